>>> design/nhg_pkg.sv
// Package for the Hamming number generator: widths, defaults and control structs.
package nhg_pkg;

  localparam int NHG_POS_W     = 11;
  localparam int NHG_VALUE_W   = 32;
  localparam int NHG_MAX_INDEX = 1024;
  localparam int NHG_SMALL_LIM = 7;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take_small;  // latch a small position as the answer
    logic take_big;    // latch the saturated position as the target count
    logic init;        // seed the store with 1, clear pointers
    logic step;        // append one entry
    logic load_out;    // move the answer into the output register
  } nhg_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic filled;      // store holds as many entries as requested
  } nhg_status_t;

endpackage

>>> design/nhg_ram.sv
// Generic single-write, single-read RAM with registered read data.
module nhg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/nhg_ctrl.sv
// Controller state machine for the Hamming number generator.
module nhg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  logic [nhg_pkg::NHG_POS_W-1:0] position,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output nhg_pkg::nhg_cmd_t   cmd,
  input  nhg_pkg::nhg_status_t status
);
  import nhg_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_INIT   = 4'b0010,
    ST_RUN    = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign req_ready = (state == ST_IDLE);
  assign out_free  = !rsp_valid || rsp_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          if (position < NHG_POS_W'(NHG_SMALL_LIM)) begin
            cmd.take_small = 1'b1;
            state_next     = ST_FINISH;
          end else begin
            cmd.take_big = 1'b1;
            state_next   = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        cmd.init   = 1'b1;
        state_next = ST_RUN;
      end
      ST_RUN: begin
        if (status.filled) begin
          state_next = ST_FINISH;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

>>> design/nhg_dp.sv
// Datapath: sequence store, three read pointers, candidate selection, output register.
module nhg_dp #(
  parameter int MAX_INDEX = nhg_pkg::NHG_MAX_INDEX
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [nhg_pkg::NHG_POS_W-1:0]   position,
  input  nhg_pkg::nhg_cmd_t               cmd,
  output nhg_pkg::nhg_status_t            status,
  output logic [nhg_pkg::NHG_VALUE_W-1:0] hamming_value
);
  import nhg_pkg::*;

  localparam int ADDR_W = $clog2(MAX_INDEX);
  localparam int CNT_W  = $clog2(MAX_INDEX + 1);
  localparam int CAND_W = NHG_VALUE_W + 3;

  logic [CNT_W-1:0]       want;
  logic [CNT_W-1:0]       fill_count;
  logic [ADDR_W-1:0]      ptr [3];
  logic [ADDR_W-1:0]      ptr_next [3];
  logic [NHG_VALUE_W-1:0] last;
  logic [NHG_POS_W-1:0]   sat_pos;

  logic                   we;
  logic [ADDR_W-1:0]      waddr;
  logic [NHG_VALUE_W-1:0] wdata;
  logic [NHG_VALUE_W-1:0] rdata [3];
  logic [NHG_VALUE_W-1:0] operand [3];
  logic [NHG_VALUE_W-1:0] byp_data;
  logic                   byp_hit [3];

  logic [CAND_W-1:0] cand [3];
  logic [CAND_W-1:0] min01, min_all;
  logic [NHG_VALUE_W-1:0] next_val;

  assign sat_pos = (position > NHG_POS_W'(MAX_INDEX)) ? NHG_POS_W'(MAX_INDEX) : position;

  assign status.filled = (fill_count == want);

  // Bypass the entry written in the same cycle as its read
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      operand[i] = byp_hit[i] ? byp_data : rdata[i];
    end
  end

  // Candidates: entry times 2, 3 and 5, built from shifts and adds
  assign cand[0] = {2'b00, operand[0], 1'b0};
  assign cand[1] = {3'b000, operand[1]} + {2'b00, operand[1], 1'b0};
  assign cand[2] = {3'b000, operand[2]} + {1'b0, operand[2], 2'b00};

  assign min01    = (cand[0] < cand[1]) ? cand[0] : cand[1];
  assign min_all  = (min01 < cand[2]) ? min01 : cand[2];
  assign next_val = min_all[NHG_VALUE_W-1:0];

  // Advance every pointer whose candidate matches, which drops duplicates
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (cmd.init) begin
        ptr_next[i] = '0;
      end else if (cmd.step && (cand[i] == min_all)) begin
        ptr_next[i] = ptr[i] + ADDR_W'(1);
      end else begin
        ptr_next[i] = ptr[i];
      end
    end
  end

  assign we    = cmd.init || cmd.step;
  assign waddr = cmd.init ? '0 : fill_count[ADDR_W-1:0];
  assign wdata = cmd.init ? NHG_VALUE_W'(1) : next_val;

  // One copy of the store per read pointer, all written together
  for (genvar g = 0; g < 3; g++) begin : g_store
    nhg_ram #(
      .WIDTH (NHG_VALUE_W),
      .DEPTH (MAX_INDEX)
    ) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (ptr_next[g]),
      .rdata (rdata[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      for (int i = 0; i < 3; i++) begin
        ptr[i]     <= '0;
        byp_hit[i] <= 1'b0;
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        ptr[i]     <= ptr_next[i];
        byp_hit[i] <= we && (waddr == ptr_next[i]);
      end
      if (cmd.init) begin
        fill_count <= CNT_W'(1);
      end else if (cmd.step) begin
        fill_count <= fill_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    byp_data <= wdata;
    if (cmd.take_big) begin
      want <= CNT_W'(sat_pos);
    end
    if (cmd.take_small) begin
      last <= NHG_VALUE_W'(position);
    end else if (we) begin
      last <= wdata;
    end
    if (cmd.load_out) begin
      hamming_value <= last;
    end
  end

endmodule

>>> design/nth_hamming_number_generator.sv
// Top level of the Hamming (5-smooth) number generator.
//
// Give a one-based position on the request channel and get back the Hamming
// number at that position (1, 2, 3, 4, 5, 6, 8, 9, 10, 12, ...) on the
// response channel. Positions below 7 return the position itself, so 0
// returns 0; positions above MAX_INDEX saturate to MAX_INDEX. One request is
// handled at a time. A small position is latched as the answer at accept, then
// moves to the output register. A larger position N (after saturation) first
// seeds the store with 1, then one entry is appended per cycle until the store
// holds N entries, then the answer moves to the output register. Each append
// step reads the entries at three pointers from three copies of the store,
// multiplies by 2, 3 and 5, keeps the smallest and advances every matching
// pointer. The next request is taken while a finished response still waits to
// be taken; its own answer then holds until the response register is free.
// Each request rebuilds the store from the start, so no clearing pass follows
// reset.
module nth_hamming_number_generator #(
  parameter int MAX_INDEX = nhg_pkg::NHG_MAX_INDEX
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_ready,
  input  logic [nhg_pkg::NHG_POS_W-1:0]   position,
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output logic [nhg_pkg::NHG_VALUE_W-1:0] hamming_value
);
  import nhg_pkg::*;

  nhg_cmd_t    cmd;
  nhg_status_t status;

  // Sequence the request: seed, append, hand off the beat
  nhg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .position  (position),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd),
    .status    (status)
  );

  // Hold the store, pointers and answer
  nhg_dp #(
    .MAX_INDEX (MAX_INDEX)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .position      (position),
    .cmd           (cmd),
    .status        (status),
    .hamming_value (hamming_value)
  );

  // At most one command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("controller issued more than one command");

  // After a request beat, no new beat is taken in the next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request accepted while busy");

  // Never append once the store holds the requested count
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> !status.filled)
    else $error("append past requested count");

  // A response beat appears only after the answer was loaded
  a_rsp_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(cmd.load_out))
    else $error("response valid without load");

endmodule
